### hw/rtl/lspe_pkg.sv
package lspe_pkg;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       file_start;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       last;
    } out_t;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_TEXT   = 1'b1;

    localparam logic [1:0] KIND_EXT     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam int HDR_CNT_W = 6;

endpackage

### hw/rtl/lsb_stego_payload_extractor.sv
// a result word passes through the input register and then the result register after its last image byte is accepted
// throughput: one image byte per cycle, sustained while results are taken
// the input register, decode logic and result register form a two-stage pass
// reset clears both configuration registers to zero and returns the decoder to idle
module lsb_stego_payload_extractor #(
    parameter int HEADER_BYTES = 54,
    parameter int MAGIC_MAX    = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               img_valid,
    output logic                               img_stall,
    input  lspe_pkg::in_t                      img,
    output logic                               res_valid,
    input  logic                               res_stall,
    output lspe_pkg::out_t                     res,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lspe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lspe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lspe_pkg::*;

    logic        in_valid_reg, in_valid_next;
    in_t         in_word_reg;
    logic        accept;
    logic        advance;
    logic        out_free;
    logic        hit;
    out_t        result;
    logic [3:0]  magic_length;
    logic [63:0] magic_text;

    assign advance       = in_valid_reg && out_free;
    assign img_stall     = in_valid_reg && !out_free;
    assign accept        = img_valid && !img_stall;
    assign in_valid_next = accept ? 1'b1 : (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= img;
    end

    lspe_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .magic_length (magic_length),
        .magic_text   (magic_text)
    );

    lspe_decoder #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAGIC_MAX    (MAGIC_MAX)
    ) u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_word_reg),
        .magic_length (magic_length),
        .magic_text   (magic_text),
        .hit          (hit),
        .result       (result)
    );

    lspe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (hit),
        .load_word (result),
        .free      (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### hw/rtl/lspe_cfg.sv
module lspe_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lspe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lspe_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [3:0]                         magic_length,
    output logic [63:0]                        magic_text
);
    import lspe_pkg::*;

    logic [3:0]  magic_length_reg;
    logic [63:0] magic_text_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_length_reg <= '0;
            magic_text_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAGIC_LENGTH: magic_length_reg <= cfg_data[3:0];
                CFG_MAGIC_TEXT:   magic_text_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign magic_length = magic_length_reg;
    assign magic_text   = magic_text_reg;

endmodule

### hw/rtl/lspe_decoder.sv
module lspe_decoder #(
    parameter int HEADER_BYTES = 54,
    parameter int MAGIC_MAX    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  lspe_pkg::in_t  item,
    input  logic [3:0]     magic_length,
    input  logic [63:0]    magic_text,
    output logic           hit,
    output lspe_pkg::out_t result
);
    import lspe_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_MAGIC   = 3'd2;
    localparam logic [2:0] PH_EXTLEN  = 3'd3;
    localparam logic [2:0] PH_EXT     = 3'd4;
    localparam logic [2:0] PH_DATALEN = 3'd5;
    localparam logic [2:0] PH_DATA    = 3'd6;

    localparam logic [HDR_CNT_W-1:0] HDR_LIMIT = HDR_CNT_W'(HEADER_BYTES);
    localparam logic [3:0]           MAGIC_CAP = 4'(MAGIC_MAX);

    logic [2:0]           phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] header_count_reg, header_count_next;
    logic [4:0]           bit_count_reg, bit_count_next;
    logic [31:0]          bit_shift_reg, bit_shift_next;
    logic [3:0]           magic_index_reg, magic_index_next;
    logic                 magic_bad_reg, magic_bad_next;
    logic [31:0]          ext_remaining_reg, ext_remaining_next;
    logic [31:0]          data_remaining_reg, data_remaining_next;

    logic [3:0] eff_len;
    logic       field_done;
    logic [7:0] expect_byte;

    assign eff_len     = (magic_length > MAGIC_CAP) ? MAGIC_CAP : magic_length;
    assign expect_byte = magic_text[{magic_index_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        bit_count_next      = bit_count_reg;
        bit_shift_next      = bit_shift_reg;
        magic_index_next    = magic_index_reg;
        magic_bad_next      = magic_bad_reg;
        ext_remaining_next  = ext_remaining_reg;
        data_remaining_next = data_remaining_reg;
        field_done          = 1'b0;
        hit                 = 1'b0;
        result              = '0;

        // a file start restarts from any phase
        if (item.file_start)
        begin
            header_count_next = '0;
            bit_count_next    = '0;
            bit_shift_next    = '0;
            if (HEADER_BYTES > 0)
            begin
                phase_next = PH_HEADER;
            end
            else
            begin
                magic_index_next = '0;
                magic_bad_next   = 1'b0;
                phase_next       = (eff_len != 4'd0) ? PH_MAGIC : PH_EXTLEN;
            end
        end

        if (phase_next == PH_HEADER)
        begin
            header_count_next = header_count_next + HDR_CNT_W'(1);
            if (header_count_next >= HDR_LIMIT)
            begin
                magic_index_next = '0;
                magic_bad_next   = 1'b0;
                bit_count_next   = '0;
                bit_shift_next   = '0;
                phase_next       = (eff_len != 4'd0) ? PH_MAGIC : PH_EXTLEN;
            end
        end
        else if (phase_next != PH_IDLE)
        begin
            bit_shift_next = {bit_shift_next[30:0], item.image_byte[0]};
            bit_count_next = bit_count_next + 5'd1;
            if (phase_next == PH_EXTLEN || phase_next == PH_DATALEN)
                field_done = (bit_count_next == 5'd0);
            else
                field_done = (bit_count_next == 5'd8);

            if (field_done)
            begin
                bit_count_next = '0;
                bit_shift_next = '0;
                unique case (phase_next)
                    PH_MAGIC:
                    begin
                        // the index register is current here: magic bytes only follow header or magic
                        if ({bit_shift_reg[6:0], item.image_byte[0]} != expect_byte)
                            magic_bad_next = 1'b1;
                        magic_index_next = magic_index_next + 4'd1;
                        if (magic_index_next >= eff_len)
                        begin
                            if (magic_bad_next)
                            begin
                                phase_next       = PH_IDLE;
                                hit              = 1'b1;
                                result.byte_kind = KIND_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        ext_remaining_next = {bit_shift_reg[30:0], item.image_byte[0]};
                        phase_next = (ext_remaining_next != '0) ? PH_EXT : PH_DATALEN;
                    end
                    PH_EXT:
                    begin
                        ext_remaining_next = ext_remaining_next - 32'd1;
                        phase_next = (ext_remaining_next != '0) ? PH_EXT : PH_DATALEN;
                        hit              = 1'b1;
                        result.out_byte  = {bit_shift_reg[6:0], item.image_byte[0]};
                        result.byte_kind = KIND_EXT;
                    end
                    PH_DATALEN:
                    begin
                        data_remaining_next = {bit_shift_reg[30:0], item.image_byte[0]};
                        phase_next = (data_remaining_next != '0) ? PH_DATA : PH_IDLE;
                    end
                    PH_DATA:
                    begin
                        data_remaining_next = data_remaining_next - 32'd1;
                        phase_next = (data_remaining_next != '0) ? PH_DATA : PH_IDLE;
                        hit              = 1'b1;
                        result.out_byte  = {bit_shift_reg[6:0], item.image_byte[0]};
                        result.byte_kind = KIND_PAYLOAD;
                        result.last      = (data_remaining_next == '0);
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        // results only count when the word actually moves on
        hit = hit & step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            header_count_reg   <= '0;
            bit_count_reg      <= '0;
            bit_shift_reg      <= '0;
            magic_index_reg    <= '0;
            magic_bad_reg      <= 1'b0;
            ext_remaining_reg  <= '0;
            data_remaining_reg <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            bit_count_reg      <= bit_count_next;
            bit_shift_reg      <= bit_shift_next;
            magic_index_reg    <= magic_index_next;
            magic_bad_reg      <= magic_bad_next;
            ext_remaining_reg  <= ext_remaining_next;
            data_remaining_reg <= data_remaining_next;
        end
    end

endmodule

### hw/rtl/lspe_out_stage.sv
module lspe_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  lspe_pkg::out_t load_word,
    output logic           free,
    output logic           res_valid,
    input  logic           res_stall,
    output lspe_pkg::out_t res
);
    import lspe_pkg::*;

    logic valid_reg, valid_next;
    out_t word_reg;

    assign free       = !valid_reg || !res_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= load_word;
    end

    assign res_valid = valid_reg;
    assign res       = word_reg;

endmodule

### hw/rtl/lspe_checker.sv
module lspe_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               img_valid,
    input logic                               img_stall,
    input logic                               res_valid,
    input logic                               res_stall,
    input lspe_pkg::out_t                     res
);
    import lspe_pkg::*;

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // input is only held off while a result waits on a stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        img_stall |-> res_valid && res_stall)
        else $error("input stalled with result stage free");

    // a fresh result follows an accepted image byte, looking back across the input and result registers
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(img_valid && !img_stall, 2))
        else $error("result word without a matching image byte");

    // last marks payload only, error notices carry zero
    a_res_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.last || res.byte_kind == KIND_PAYLOAD)
                   && (res.byte_kind != KIND_ERROR || res.out_byte == 8'd0))
        else $error("malformed result word");

endmodule

bind lsb_stego_payload_extractor lspe_checker u_lspe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .img_valid (img_valid),
    .img_stall (img_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
